// ===== src/fqr_pkg.sv =====
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types, constants and helpers for the keyed-delete fifo queue.
// ----------------------------------------------------------------------------
package fqr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int TIME_BITS   = 32;
    localparam int ACTION_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    localparam logic [TIME_BITS-1:0] EMPTY_HEAD_TIME = TIME_BITS'(64'd999999999);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN,
        ST_SHIFT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic [ID_BITS-1:0]     item_id;
        logic [TIME_BITS-1:0]   arrival_time;
    } req_word_t;

    typedef struct packed {
        logic                  ok;
        logic [ID_BITS-1:0]    out_id;
        logic [TIME_BITS-1:0]  out_time;
        logic [TIME_BITS-1:0]  head_time;
        logic                  queue_empty;
        logic [COUNT_BITS-1:0] queue_count;
    } rsp_word_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        logic [TIME_BITS-1:0] arrival;
    } entry_t;

    // one access per port, indexes are relative to the head
    typedef struct packed {
        logic   rd_en;
        ptr_t   rd_idx;
        logic   wr_en;
        ptr_t   wr_idx;
        entry_t wr_entry;
    } mem_cmd_t;

    // circular add, both operands below QUEUE_DEPTH
    function automatic ptr_t ptr_add(input ptr_t a, input ptr_t b);
        logic [PTR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (PTR_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

// ===== src/fqr_req_if.sv =====
// ----------------------------------------------------------------------------
// fqr_req_if
// Valid/ready channel carrying one queue request word.
// ----------------------------------------------------------------------------
interface fqr_req_if;

    logic               valid;
    logic               ready;
    fqr_pkg::req_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== src/fqr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fqr_rsp_if
// Valid/ready channel carrying one queue result word.
// ----------------------------------------------------------------------------
interface fqr_rsp_if;

    logic               valid;
    logic               ready;
    fqr_pkg::rsp_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== src/fqr_store.sv =====
// ----------------------------------------------------------------------------
// fqr_store
// Entry memory of the queue: circular array addressed relative to the head,
// one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fqr_store
(
    input  logic               clk,
    input  fqr_pkg::ptr_t      head,
    input  fqr_pkg::mem_cmd_t  cmd,
    output fqr_pkg::entry_t    rd_data
);

    fqr_pkg::entry_t mem [fqr_pkg::QUEUE_DEPTH];
    fqr_pkg::ptr_t   rd_phys;
    fqr_pkg::ptr_t   wr_phys;

    assign rd_phys = fqr_pkg::ptr_add(head, cmd.rd_idx);
    assign wr_phys = fqr_pkg::ptr_add(head, cmd.wr_idx);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_phys] <= cmd.wr_entry;
        end
        if (cmd.rd_en)
        begin
            rd_data <= mem[rd_phys];
        end
    end

endmodule

// ===== src/fifo_queue_with_remove_by_id_core.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id_core
// Bounded fifo of (id, arrival time) entries with push, pop, keyed remove
// and clear; one result word per request.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. The entries sit in a single circular
// memory with one read and one write port, so every cycle moves at most one
// entry. Push, clear, a failing push or pop and a remove on an empty queue
// go from acceptance straight to the result state; a pop passes through the
// pop state first. A keyed remove walks the memory from the head one entry
// a cycle until the id matches, then moves each later entry down by one slot
// a cycle; a match at the head only advances the head. The result sits in an
// output register and a new request is taken only once the previous result
// is loaded there.
module fifo_queue_with_remove_by_id_core
(
    input  logic      clk,
    input  logic      rst_n,
    fqr_req_if.sink   req,
    fqr_rsp_if.source rsp
);

    fqr_pkg::state_t  state_reg,     state_next;
    fqr_pkg::ptr_t    head_reg,      head_next;
    fqr_pkg::cnt_t    count_reg,     count_next;
    fqr_pkg::ptr_t    idx_reg,       idx_next;
    logic [fqr_pkg::ID_BITS-1:0]   op_id_reg,    op_id_next;
    logic [fqr_pkg::TIME_BITS-1:0] op_time_reg,  op_time_next;
    logic                          ok_reg,       ok_next;
    logic [fqr_pkg::ID_BITS-1:0]   pop_id_reg,   pop_id_next;
    logic [fqr_pkg::TIME_BITS-1:0] pop_time_reg, pop_time_next;
    logic                          fwd_reg,      fwd_next;
    logic                          out_valid_reg, out_valid_next;
    fqr_pkg::rsp_word_t            out_word_reg,  out_word_next;

    fqr_pkg::mem_cmd_t mem_cmd;
    fqr_pkg::entry_t   rd_data;
    fqr_pkg::cnt_t     idx_plus1;
    logic              accept;

    fqr_store u_store
    (
        .clk     (clk),
        .head    (head_reg),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    assign idx_plus1 = fqr_pkg::cnt_t'(idx_reg) + fqr_pkg::cnt_t'(1);
    assign req.ready = (state_reg == fqr_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fqr_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        op_id_reg     <= op_id_next;
        op_time_reg   <= op_time_next;
        ok_reg        <= ok_next;
        pop_id_reg    <= pop_id_next;
        pop_time_reg  <= pop_time_next;
        fwd_reg       <= fwd_next;
        out_word_reg  <= out_word_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        op_id_next     = op_id_reg;
        op_time_next   = op_time_reg;
        ok_next        = ok_reg;
        pop_id_next    = pop_id_reg;
        pop_time_next  = pop_time_reg;
        fwd_next       = fwd_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_cmd        = '0;

        unique case (state_reg)
            fqr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_id_next     = req.data.item_id;
                    op_time_next   = req.data.arrival_time;
                    ok_next        = 1'b0;
                    pop_id_next    = '0;
                    pop_time_next  = '0;
                    fwd_next       = 1'b0;
                    // head read for the result unless another state takes over
                    mem_cmd.rd_en  = 1'b1;
                    mem_cmd.rd_idx = '0;
                    state_next     = fqr_pkg::ST_RESULT;
                    unique case (fqr_pkg::action_t'(req.data.action))
                        fqr_pkg::ACT_PUSH:
                        begin
                            if (count_reg < fqr_pkg::cnt_t'(fqr_pkg::QUEUE_DEPTH))
                            begin
                                mem_cmd.wr_en            = 1'b1;
                                mem_cmd.wr_idx           = count_reg[fqr_pkg::PTR_W-1:0];
                                mem_cmd.wr_entry.id      = req.data.item_id;
                                mem_cmd.wr_entry.arrival = req.data.arrival_time;
                                count_next = count_reg + fqr_pkg::cnt_t'(1);
                                ok_next    = 1'b1;
                                // pushing into an empty queue: head read misses the write
                                fwd_next   = (count_reg == '0);
                            end
                        end
                        fqr_pkg::ACT_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = fqr_pkg::ST_POP;
                            end
                        end
                        fqr_pkg::ACT_REMOVE:
                        begin
                            if (count_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = fqr_pkg::ST_SCAN;
                            end
                        end
                        fqr_pkg::ACT_CLEAR:
                        begin
                            mem_cmd.rd_en = 1'b0;
                            count_next    = '0;
                            head_next     = '0;
                            ok_next       = 1'b1;
                        end
                        default:
                        begin
                            state_next = fqr_pkg::ST_RESULT;
                        end
                    endcase
                end
            end

            fqr_pkg::ST_POP:
            begin
                pop_id_next    = rd_data.id;
                pop_time_next  = rd_data.arrival;
                ok_next        = 1'b1;
                head_next      = fqr_pkg::ptr_add(head_reg, fqr_pkg::ptr_t'(1));
                count_next     = count_reg - fqr_pkg::cnt_t'(1);
                mem_cmd.rd_en  = 1'b1;
                mem_cmd.rd_idx = fqr_pkg::ptr_t'(1);
                state_next     = fqr_pkg::ST_RESULT;
            end

            fqr_pkg::ST_SCAN:
            begin
                mem_cmd.rd_en = 1'b1;
                if (rd_data.id == op_id_reg)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg - fqr_pkg::cnt_t'(1);
                    if (idx_reg == '0)
                    begin
                        head_next      = fqr_pkg::ptr_add(head_reg, fqr_pkg::ptr_t'(1));
                        mem_cmd.rd_idx = fqr_pkg::ptr_t'(1);
                        state_next     = fqr_pkg::ST_RESULT;
                    end
                    else if (idx_plus1 == count_reg)
                    begin
                        // match on the tail entry: nothing to move
                        mem_cmd.rd_idx = '0;
                        state_next     = fqr_pkg::ST_RESULT;
                    end
                    else
                    begin
                        mem_cmd.rd_idx = idx_plus1[fqr_pkg::PTR_W-1:0];
                        state_next     = fqr_pkg::ST_SHIFT;
                    end
                end
                else if (idx_plus1 < count_reg)
                begin
                    mem_cmd.rd_idx = idx_plus1[fqr_pkg::PTR_W-1:0];
                    idx_next       = idx_plus1[fqr_pkg::PTR_W-1:0];
                end
                else
                begin
                    mem_cmd.rd_idx = '0;
                    state_next     = fqr_pkg::ST_RESULT;
                end
            end

            fqr_pkg::ST_SHIFT:
            begin
                // rd_data holds the entry behind idx_reg; count_reg is already reduced
                mem_cmd.wr_en    = 1'b1;
                mem_cmd.wr_idx   = idx_reg;
                mem_cmd.wr_entry = rd_data;
                mem_cmd.rd_en    = 1'b1;
                if (idx_plus1 == count_reg)
                begin
                    mem_cmd.rd_idx = '0;
                    state_next     = fqr_pkg::ST_RESULT;
                end
                else
                begin
                    mem_cmd.rd_idx = idx_reg + fqr_pkg::ptr_t'(2);
                    idx_next       = idx_plus1[fqr_pkg::PTR_W-1:0];
                end
            end

            fqr_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next        = 1'b1;
                    out_word_next.ok      = ok_reg;
                    out_word_next.out_id  = pop_id_reg;
                    out_word_next.out_time = pop_time_reg;
                    if (count_reg == '0)
                    begin
                        out_word_next.head_time = fqr_pkg::EMPTY_HEAD_TIME;
                    end
                    else if (fwd_reg)
                    begin
                        out_word_next.head_time = op_time_reg;
                    end
                    else
                    begin
                        out_word_next.head_time = rd_data.arrival;
                    end
                    out_word_next.queue_empty = (count_reg == '0);
                    out_word_next.queue_count = fqr_pkg::COUNT_BITS'(count_reg);
                    state_next = fqr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fqr_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= fqr_pkg::cnt_t'(fqr_pkg::QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fqr_pkg::ST_SCAN) |-> (idx_plus1 <= count_reg))
        else $error("scan index beyond held entries");

    a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_cmd.wr_en && mem_cmd.rd_en && state_reg == fqr_pkg::ST_SHIFT)
            |-> (mem_cmd.wr_idx != mem_cmd.rd_idx))
        else $error("shift reads the slot it writes");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fqr_pkg::ST_RESULT))
        else $error("result loaded outside the result state");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != fqr_pkg::ST_IDLE && state_reg != fqr_pkg::ST_RESULT)
            |=> (count_reg == $past(count_reg)
                 || count_reg == $past(count_reg) - fqr_pkg::cnt_t'(1)))
        else $error("count moved by more than one during pop or remove");
`endif

endmodule
